>>> rtl/cpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cluster purity counter.
// No dependencies; every other file of the block refers to this package.
package cpc_pkg;

    localparam int CPC_LABEL_W   = 16;   // label fields, signed
    localparam int CPC_CFG_W     = 5;    // configuration registers and write data
    localparam int CPC_LIM_W     = 9;    // limited row/column counts, up to 256
    localparam int CPC_ADDR_W    = 16;   // table address, enough for 256 x 256 cells
    localparam int CPC_OUT_W     = 32;   // emitted totals
    localparam int CPC_PURITY_W  = 17;   // purity, unsigned Q1.16 up to 1.0
    localparam int CPC_FRAC_BITS = 16;   // fraction bits of the purity

    localparam logic [CPC_PURITY_W-1:0] CPC_ONE_Q16 = 17'h1_0000;

    // Register indexes of the configuration port
    localparam logic CPC_REG_PRED = 1'b0;
    localparam logic CPC_REG_TRUE = 1'b1;

    // Request codes of the input item
    localparam logic CPC_REQ_ADD    = 1'b0;
    localparam logic CPC_REQ_FINISH = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic signed [CPC_LABEL_W-1:0] pred_label;
        logic signed [CPC_LABEL_W-1:0] true_label;
    } t_cpc_in;

    typedef struct packed {
        logic [CPC_OUT_W-1:0]    correct_total;
        logic [CPC_OUT_W-1:0]    sample_total;
        logic [CPC_PURITY_W-1:0] purity_q16;
    } t_cpc_out;

    // Operation classes handed from the front to the back
    typedef enum logic [1:0] {
        CPC_OP_COUNT  = 2'b00,   // sample only, labels out of range
        CPC_OP_CELL   = 2'b01,   // sample and one table cell
        CPC_OP_FINISH = 2'b10    // sweep the table and emit
    } t_cpc_kind;

    typedef struct packed {
        t_cpc_kind             kind;
        logic [CPC_ADDR_W-1:0] addr;
    } t_cpc_op;

    // Rows and columns in use, already limited to the table size
    typedef struct packed {
        logic [CPC_LIM_W-1:0] rows;
        logic [CPC_LIM_W-1:0] cols;
    } t_cpc_cfg;

endpackage

>>> rtl/cpc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input transfer and label classification.
// Depends on cpc_pkg; feeds operations into cpc_queue.
module cpc_front #(
    parameter int MAX_PRED_CLUSTERS = 16,
    parameter int MAX_TRUE_CLASSES  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [cpc_pkg::CPC_CFG_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  cpc_pkg::t_cpc_in             i_in_data,
    input  logic                         i_hold,
    input  logic                         i_q_full,
    output logic                         o_in_stall,
    output logic                         o_push,
    output cpc_pkg::t_cpc_op             o_op,
    output cpc_pkg::t_cpc_cfg            o_cfg
);

    localparam int RW  = (MAX_PRED_CLUSTERS > 1) ? $clog2(MAX_PRED_CLUSTERS) : 1;
    localparam int CLW = (MAX_TRUE_CLASSES > 1) ? $clog2(MAX_TRUE_CLASSES) : 1;
    localparam int LW  = cpc_pkg::CPC_LABEL_W;
    localparam int MW  = cpc_pkg::CPC_LIM_W;

    logic [cpc_pkg::CPC_CFG_W-1:0] r_pred_used;
    logic [cpc_pkg::CPC_CFG_W-1:0] r_true_used;
    logic [MW-1:0]                 rows_lim;
    logic [MW-1:0]                 cols_lim;
    logic                          pred_ok;
    logic                          true_ok;
    logic [RW-1:0]                 p_idx;
    logic [CLW-1:0]                t_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_used <= cpc_pkg::CPC_CFG_W'(16);
            r_true_used <= cpc_pkg::CPC_CFG_W'(16);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cpc_pkg::CPC_REG_PRED) begin
                r_pred_used <= i_cfg_data;
            end else begin
                r_true_used <= i_cfg_data;
            end
        end
    end

    // Limit each register to the table size
    assign rows_lim = (MW'(r_pred_used) > MW'(MAX_PRED_CLUSTERS)) ?
                      MW'(MAX_PRED_CLUSTERS) : MW'(r_pred_used);
    assign cols_lim = (MW'(r_true_used) > MW'(MAX_TRUE_CLASSES)) ?
                      MW'(MAX_TRUE_CLASSES) : MW'(r_true_used);

    assign o_cfg.rows = rows_lim;
    assign o_cfg.cols = cols_lim;

    // A label is in range when it is non-negative and below its limit
    assign pred_ok = !i_in_data.pred_label[LW-1] &&
                     ({1'b0, i_in_data.pred_label[LW-2:0]} < LW'(rows_lim));
    assign true_ok = !i_in_data.true_label[LW-1] &&
                     ({1'b0, i_in_data.true_label[LW-2:0]} < LW'(cols_lim));

    assign p_idx = i_in_data.pred_label[RW-1:0];
    assign t_idx = i_in_data.true_label[CLW-1:0];

    assign o_in_stall = i_q_full || i_hold;
    assign o_push     = i_in_valid && !o_in_stall;

    always_comb begin
        o_op.addr = '0;
        if (i_in_data.req_type == cpc_pkg::CPC_REQ_FINISH) begin
            o_op.kind = cpc_pkg::CPC_OP_FINISH;
        end else if (pred_ok && true_ok) begin
            o_op.kind = cpc_pkg::CPC_OP_CELL;
            o_op.addr = cpc_pkg::CPC_ADDR_W'(32'(p_idx) * 32'(MAX_TRUE_CLASSES)
                                             + 32'(t_idx));
        end else begin
            o_op.kind = cpc_pkg::CPC_OP_COUNT;
        end
    end

endmodule

>>> rtl/cpc_queue.sv
`timescale 1ns / 1ps
// Two-entry operation queue between the front and the back.
// Depends on cpc_pkg for the operation type.
module cpc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cpc_pkg::t_cpc_op i_op,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output cpc_pkg::t_cpc_op o_op
);

    cpc_pkg::t_cpc_op r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_slot[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

>>> rtl/cpc_div.sv
`timescale 1ns / 1ps
// Restoring divider for the purity fraction, one quotient bit per cycle.
// Depends on cpc_pkg for the fraction width.
module cpc_div #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [COUNT_WIDTH-1:0]            i_num,
    input  logic [COUNT_WIDTH-1:0]            i_den,
    output logic                              o_done,
    output logic [cpc_pkg::CPC_PURITY_W-1:0]  o_quot
);

    localparam int FB = cpc_pkg::CPC_FRAC_BITS;
    localparam int NW = $clog2(FB + 1);

    logic                             r_busy;
    logic                             r_done;
    logic [NW-1:0]                    r_cnt;
    logic [COUNT_WIDTH-1:0]           r_rem;
    logic [COUNT_WIDTH-1:0]           r_den;
    logic [cpc_pkg::CPC_PURITY_W-1:0] r_quot;
    logic [COUNT_WIDTH:0]             rem2;
    logic [COUNT_WIDTH:0]             diff;
    logic                             ge;

    assign rem2 = {r_rem, 1'b0};
    assign diff = rem2 - {1'b0, r_den};
    assign ge   = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // Zero samples and a full ratio finish at once
                if (i_den == '0 || i_num >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= NW'(FB);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            if (i_den == '0) begin
                r_quot <= '0;
            end else if (i_num >= i_den) begin
                r_quot <= cpc_pkg::CPC_ONE_Q16;
            end else begin
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= ge ? diff[COUNT_WIDTH-1:0] : rem2[COUNT_WIDTH-1:0];
            r_quot <= {r_quot[cpc_pkg::CPC_PURITY_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/cpc_back.sv
`timescale 1ns / 1ps
// Back end: contingency table memory, read-modify-write pipe, finish sweep,
// purity division and result register. Depends on cpc_pkg and cpc_div.
module cpc_back #(
    parameter int MAX_PRED_CLUSTERS = 16,
    parameter int MAX_TRUE_CLASSES  = 16,
    parameter int COUNT_WIDTH       = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpc_pkg::t_cpc_cfg i_cfg,
    input  logic              i_op_valid,
    input  cpc_pkg::t_cpc_op  i_op,
    output logic              o_op_pop,
    output logic              o_clearing,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cpc_pkg::t_cpc_out o_out_data
);

    localparam int DEPTH = MAX_PRED_CLUSTERS * MAX_TRUE_CLASSES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_PRED_CLUSTERS > 1) ? $clog2(MAX_PRED_CLUSTERS) : 1;
    localparam int CLW   = (MAX_TRUE_CLASSES > 1) ? $clog2(MAX_TRUE_CLASSES) : 1;
    localparam int CW    = COUNT_WIDTH;
    localparam int OW    = (CW > cpc_pkg::CPC_OUT_W) ? CW : cpc_pkg::CPC_OUT_W;
    localparam int MW    = cpc_pkg::CPC_LIM_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_RUN   = 7'b0000010,
        S_SWEEP = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_START = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state          r_state;
    t_state          n_state;

    logic [CW-1:0]   r_table [DEPTH];
    logic [CW-1:0]   r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [CW-1:0]   mem_wd;
    logic [AW-1:0]   mem_ra;

    logic            r_b_valid;
    logic [AW-1:0]   r_b_addr;
    logic            r_fw_valid;
    logic [AW-1:0]   r_fw_addr;
    logic [CW-1:0]   r_fw_data;
    logic [CW-1:0]   b_old;
    logic [CW-1:0]   b_new;

    logic [AW-1:0]   r_sw_addr;
    logic [RW-1:0]   r_sw_row;
    logic [CLW-1:0]  r_sw_col;
    logic            sw_last_col;
    logic            sw_end;

    logic            r_cmp_valid;
    logic            r_cmp_use;
    logic            r_cmp_last;
    logic [CW-1:0]   r_row_max;
    logic [CW-1:0]   cand;
    logic [CW-1:0]   cmp_max;
    logic [CW:0]     sum;

    logic [CW-1:0]   r_samples;
    logic [CW-1:0]   r_correct;

    logic            pop;
    logic            take_cell;
    logic            count_sample;
    logic            sweep_step;
    logic            div_start;
    logic            div_done;
    logic [cpc_pkg::CPC_PURITY_W-1:0] div_quot;
    logic            load_out;
    logic [OW-1:0]   correct_ext;
    logic [OW-1:0]   samples_ext;

    logic            r_out_valid;
    cpc_pkg::t_cpc_out r_out;

    // ---------------- control ----------------
    assign sw_last_col = (r_sw_col == CLW'(MAX_TRUE_CLASSES - 1));
    assign sw_end      = (r_sw_addr == AW'(DEPTH - 1));
    assign load_out    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        pop          = 1'b0;
        take_cell    = 1'b0;
        count_sample = 1'b0;
        sweep_step   = 1'b0;
        div_start    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                sweep_step = 1'b1;
                if (sw_end) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_op_valid) begin
                    pop = 1'b1;
                    unique case (i_op.kind)
                        cpc_pkg::CPC_OP_CELL: begin
                            take_cell    = 1'b1;
                            count_sample = 1'b1;
                        end
                        cpc_pkg::CPC_OP_FINISH: begin
                            n_state = S_SWEEP;
                        end
                        default: begin
                            count_sample = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                sweep_step = 1'b1;
                if (sw_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_START;
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_op_pop   = pop;
    assign o_clearing = (r_state == S_CLEAR);

    // ---------------- table memory ----------------
    // Increment with a bypass of the write that lands as the read is taken
    assign b_old = (r_fw_valid && r_fw_addr == r_b_addr) ? r_fw_data : r_rdata;
    assign b_new = (b_old == '1) ? b_old : b_old + CW'(1);

    assign mem_we = r_b_valid || sweep_step;
    assign mem_wa = r_b_valid ? r_b_addr : r_sw_addr;
    assign mem_wd = r_b_valid ? b_new : '0;
    assign mem_ra = (r_state == S_SWEEP) ? r_sw_addr : i_op.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wa] <= mem_wd;
        end
        r_rdata <= r_table[mem_ra];
    end

    // ---------------- row maximum and correct total ----------------
    assign cand    = r_cmp_use ? r_rdata : '0;
    assign cmp_max = (cand > r_row_max) ? cand : r_row_max;
    assign sum     = {1'b0, r_correct} + {1'b0, cmp_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_b_valid   <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_sw_addr   <= '0;
            r_sw_row    <= '0;
            r_sw_col    <= '0;
            r_cmp_valid <= 1'b0;
            r_row_max   <= '0;
            r_samples   <= '0;
            r_correct   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_b_valid   <= take_cell;
            r_fw_valid  <= r_b_valid;
            r_cmp_valid <= (r_state == S_SWEEP);

            if (sweep_step) begin
                if (sw_end) begin
                    r_sw_addr <= '0;
                    r_sw_row  <= '0;
                    r_sw_col  <= '0;
                end else begin
                    r_sw_addr <= r_sw_addr + AW'(1);
                    if (sw_last_col) begin
                        r_sw_col <= '0;
                        r_sw_row <= r_sw_row + RW'(1);
                    end else begin
                        r_sw_col <= r_sw_col + CLW'(1);
                    end
                end
            end

            if (r_cmp_valid) begin
                if (r_cmp_last) begin
                    r_row_max <= '0;
                    r_correct <= sum[CW] ? '1 : sum[CW-1:0];
                end else begin
                    r_row_max <= cmp_max;
                end
            end

            if (load_out) begin
                r_samples <= '0;
                r_correct <= '0;
            end else if (count_sample && r_samples != '1) begin
                r_samples <= r_samples + CW'(1);
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_cell) begin
            r_b_addr <= i_op.addr[AW-1:0];
        end
        if (r_b_valid) begin
            r_fw_addr <= r_b_addr;
            r_fw_data <= b_new;
        end
        r_cmp_use  <= (MW'(r_sw_row) < i_cfg.rows) && (MW'(r_sw_col) < i_cfg.cols);
        r_cmp_last <= sw_last_col;
        if (load_out) begin
            r_out.correct_total <= (correct_ext > OW'(32'hFFFF_FFFF)) ?
                                   32'hFFFF_FFFF : correct_ext[cpc_pkg::CPC_OUT_W-1:0];
            r_out.sample_total  <= (samples_ext > OW'(32'hFFFF_FFFF)) ?
                                   32'hFFFF_FFFF : samples_ext[cpc_pkg::CPC_OUT_W-1:0];
            r_out.purity_q16    <= div_quot;
        end
    end

    assign correct_ext = OW'(r_correct);
    assign samples_ext = OW'(r_samples);

    // ---------------- purity ----------------
    cpc_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_correct),
        .i_den   (r_samples),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/cluster_purity_counter.sv
`timescale 1ns / 1ps
// Add items: one transfer per cycle while the input is not stalled by the clearing pass or a full queue.
// Finish item: the result follows a sweep that reads and zeroes every table cell,
// then the divider, which yields the quotient one bit at a time.
// Reset: a clearing pass that zeroes every table cell, with the
// input stalled; configuration writes are taken throughout.
//
// Top level of the cluster purity counter. Depends on cpc_pkg, cpc_front,
// cpc_queue, cpc_back and cpc_div.
module cluster_purity_counter #(
    parameter int MAX_PRED_CLUSTERS = 16,
    parameter int MAX_TRUE_CLASSES  = 16,
    parameter int COUNT_WIDTH       = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [cpc_pkg::CPC_CFG_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cpc_pkg::t_cpc_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cpc_pkg::t_cpc_out             o_out_data
);

    // The front classifies each transfer into an operation: count only,
    // count and bump one cell, or finish. Configuration lives there too,
    // already limited to the table size for the back end.
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              clearing;
    cpc_pkg::t_cpc_op  front_op;
    cpc_pkg::t_cpc_op  head_op;
    cpc_pkg::t_cpc_cfg cfg;

    cpc_front #(
        .MAX_PRED_CLUSTERS (MAX_PRED_CLUSTERS),
        .MAX_TRUE_CLASSES  (MAX_TRUE_CLASSES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_hold     (clearing),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_op       (front_op),
        .o_cfg      (cfg)
    );

    // Two entries decouple the input stall from the back end, which holds
    // off during a finish sweep while the front takes transfers until the queue fills.
    cpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    // The back end owns the table: a read then an increment-and-write with a
    // one-entry bypass, a sweep that reads and zeroes every cell on finish,
    // the divider and the result register. Further adds proceed while a
    // result waits in the output register.
    cpc_back #(
        .MAX_PRED_CLUSTERS (MAX_PRED_CLUSTERS),
        .MAX_TRUE_CLASSES  (MAX_TRUE_CLASSES),
        .COUNT_WIDTH       (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_op_valid  (q_valid),
        .i_op        (head_op),
        .o_op_pop    (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Purity never exceeds one
    a_purity_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.purity_q16 <= cpc_pkg::CPC_ONE_Q16))
        else $error("purity above 1.0");

    // Row maxima can never add up to more than the samples taken
    a_correct_le_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.correct_total <= o_out_data.sample_total))
        else $error("correct total exceeds sample total");

    // An empty batch gives zero everywhere
    a_empty_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sample_total == '0) |->
        (o_out_data.correct_total == '0 && o_out_data.purity_q16 == '0))
        else $error("empty batch with non-zero result");

    // A fully pure batch reads exactly one
    a_full_purity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sample_total != '0 &&
         o_out_data.correct_total == o_out_data.sample_total) |->
        (o_out_data.purity_q16 == cpc_pkg::CPC_ONE_Q16))
        else $error("pure batch not reported as 1.0");

endmodule
